// File: rtl/core/arith_expression_syntax_checker_top_defines.svh
// Assertion macros for the checker in aesc_checker.sv.
`ifndef ARITH_EXPRESSION_SYNTAX_CHECKER_TOP_DEFINES_SVH
`define ARITH_EXPRESSION_SYNTAX_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define AESC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checker property violated");

// Next-cycle implication, disabled while reset is asserted
`define AESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checker property violated");

`endif

// File: rtl/core/aesc_pkg.sv
package aesc_pkg;

  // Bracket depth counter width and its saturation point
  localparam int unsigned DEPTH_BITS = 8;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  // Character codes
  localparam logic [15:0] CH_OPEN  = 16'h0028;
  localparam logic [15:0] CH_CLOSE = 16'h0029;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_STAR  = 16'h002A;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_ONE   = 16'h0031;
  localparam logic [15:0] CH_NINE  = 16'h0039;

  // Verdict and error codes
  localparam logic [3:0] VERDICT_OK        = 4'd0;
  localparam logic [3:0] VERDICT_EMPTY     = 4'd1;
  localparam logic [3:0] VERDICT_MALFORMED = 4'd2;
  localparam logic [3:0] VERDICT_NUM_ONLY  = 4'd3;
  localparam logic [3:0] VERDICT_MULTI_DOT = 4'd4;
  localparam logic [3:0] VERDICT_TWO_OPS   = 4'd5;
  localparam logic [3:0] VERDICT_ZERO_DIV  = 4'd6;
  localparam logic [3:0] VERDICT_UNBAL     = 4'd7;
  localparam logic [3:0] VERDICT_TOO_DEEP  = 4'd8;
  localparam logic [3:0] VERDICT_MAX       = VERDICT_TOO_DEEP;

  // Pending check on the next non-space character
  typedef enum logic [1:0] {
    LA_NONE  = 2'd0,
    LA_OPEN  = 2'd1,
    LA_CLOSE = 2'd2,
    LA_OP    = 2'd3
  } lookahead_t;

  // Per-expression scan state
  typedef struct packed {
    logic [DEPTH_BITS-1:0] bracket_depth;
    logic                  first_char_done;
    logic                  first_char_bad;
    logic                  saw_operator_char;
    logic                  in_number_run;
    logic                  dot_seen_in_run;
    lookahead_t            lookahead_kind;
    logic                  divide_pending;
    logic                  zero_divisor_scan;
    logic                  dot_error_deferred;
    logic [3:0]            first_error;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    bracket_depth:      '0,
    first_char_done:    1'b0,
    first_char_bad:     1'b0,
    saw_operator_char:  1'b0,
    in_number_run:      1'b0,
    dot_seen_in_run:    1'b0,
    lookahead_kind:     LA_NONE,
    divide_pending:     1'b0,
    zero_divisor_scan:  1'b0,
    dot_error_deferred: 1'b0,
    first_error:        VERDICT_OK
  };

  // Keep the earliest error
  function automatic logic [3:0] rec_err(logic [3:0] cur, logic [3:0] code);
    return (cur == VERDICT_OK) ? code : cur;
  endfunction

endpackage

// File: rtl/core/aesc_step.sv
module aesc_step (
  input  aesc_pkg::scan_state_t st,
  input  logic [15:0]           char_code,
  input  logic                  last_char,
  input  logic                  empty_expr,
  output aesc_pkg::scan_state_t st_nxt,
  output logic                  has_result,
  output logic [3:0]            verdict
);

  logic                  is_dig;
  logic                  is_zero;
  logic                  is_dot;
  logic                  is_space;
  logic                  is_open;
  logic                  is_close;
  logic                  is_plus;
  logic                  is_minus;
  logic                  is_star;
  logic                  is_slash;
  logic                  is_op;

  // Classify the incoming character
  always_comb begin
    is_dig    = (char_code >= aesc_pkg::CH_ZERO) && (char_code <= aesc_pkg::CH_NINE);
    is_zero   = (char_code == aesc_pkg::CH_ZERO);
    is_dot    = (char_code == aesc_pkg::CH_DOT);
    is_space  = (char_code == aesc_pkg::CH_SPACE);
    is_open   = (char_code == aesc_pkg::CH_OPEN);
    is_close  = (char_code == aesc_pkg::CH_CLOSE);
    is_plus   = (char_code == aesc_pkg::CH_PLUS);
    is_minus  = (char_code == aesc_pkg::CH_MINUS);
    is_star   = (char_code == aesc_pkg::CH_STAR);
    is_slash  = (char_code == aesc_pkg::CH_SLASH);
    is_op     = is_plus | is_minus | is_star | is_slash;
  end

  // Advance the scan state by one character and form the verdict
  always_comb begin
    aesc_pkg::scan_state_t s;
    s          = st;
    has_result = 1'b0;
    verdict    = aesc_pkg::VERDICT_OK;

    if (empty_expr) begin
      s          = aesc_pkg::SCAN_CLEAR;
      has_result = 1'b1;
      verdict    = aesc_pkg::VERDICT_EMPTY;
    end else begin
      // First character check
      if (!s.first_char_done) begin
        s.first_char_done = 1'b1;
        s.first_char_bad  = !(is_open | is_dig | is_minus | is_dot);
      end
      if (is_op | is_open | is_close | is_dot | is_space) begin
        s.saw_operator_char = 1'b1;
      end

      // Close an open zero divisor scan
      if (s.zero_divisor_scan && !is_zero && !is_dot && !is_space) begin
        s.zero_divisor_scan = 1'b0;
        if (is_dig) begin
          if (s.dot_error_deferred) begin
            s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_MULTI_DOT);
          end
        end else begin
          s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_ZERO_DIV);
        end
        s.dot_error_deferred = 1'b0;
      end

      if (is_space) begin
        s.in_number_run = 1'b0;
      end else begin
        // Pending lookahead check
        case (s.lookahead_kind)
          aesc_pkg::LA_OPEN: begin
            if (is_plus | is_star | is_slash | is_close) begin
              s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_MALFORMED);
            end
          end
          aesc_pkg::LA_CLOSE: begin
            if (is_dig | is_open | is_dot) begin
              s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_MALFORMED);
            end
          end
          aesc_pkg::LA_OP: begin
            if (is_op | is_close) begin
              s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_TWO_OPS);
            end else if (s.divide_pending && is_zero) begin
              s.zero_divisor_scan = 1'b1;
            end
          end
          default: ;
        endcase
        s.lookahead_kind = aesc_pkg::LA_NONE;
        s.divide_pending = 1'b0;

        // Illegal character
        if (!is_dig && !is_op && !is_open && !is_close && !is_dot) begin
          s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_MALFORMED);
        end

        if (is_dig | is_dot) begin
          // Track dots within a number
          if (!s.in_number_run) begin
            s.in_number_run   = 1'b1;
            s.dot_seen_in_run = is_dot;
          end else if (is_dot) begin
            if (s.dot_seen_in_run) begin
              if (s.zero_divisor_scan) begin
                s.dot_error_deferred = 1'b1;
              end else begin
                s.first_error = aesc_pkg::rec_err(s.first_error,
                                                  aesc_pkg::VERDICT_MULTI_DOT);
              end
            end
            s.dot_seen_in_run = 1'b1;
          end
        end else begin
          s.in_number_run = 1'b0;
          if (is_open) begin
            if (s.bracket_depth >= aesc_pkg::DEPTH_MAX) begin
              s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_TOO_DEEP);
            end else begin
              s.bracket_depth = s.bracket_depth + aesc_pkg::DEPTH_ONE;
            end
            s.lookahead_kind = aesc_pkg::LA_OPEN;
          end else if (is_close) begin
            if (s.bracket_depth == '0) begin
              s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_MALFORMED);
            end else begin
              s.bracket_depth = s.bracket_depth - aesc_pkg::DEPTH_ONE;
            end
            s.lookahead_kind = aesc_pkg::LA_CLOSE;
          end else if (is_op) begin
            s.lookahead_kind = aesc_pkg::LA_OP;
            s.divide_pending = is_slash;
          end
        end
      end

      // Final character: resolve the verdict and clear for the next expression
      if (last_char) begin
        if (s.zero_divisor_scan) begin
          s.first_error = aesc_pkg::rec_err(s.first_error, aesc_pkg::VERDICT_ZERO_DIV);
        end
        has_result = 1'b1;
        if (s.first_char_bad) begin
          verdict = aesc_pkg::VERDICT_MALFORMED;
        end else if (!(is_close | is_dig | is_dot)) begin
          verdict = aesc_pkg::VERDICT_MALFORMED;
        end else if (!s.saw_operator_char) begin
          verdict = aesc_pkg::VERDICT_NUM_ONLY;
        end else if (s.first_error != aesc_pkg::VERDICT_OK) begin
          verdict = s.first_error;
        end else if (s.bracket_depth != '0) begin
          verdict = aesc_pkg::VERDICT_UNBAL;
        end else begin
          verdict = aesc_pkg::VERDICT_OK;
        end
        s = aesc_pkg::SCAN_CLEAR;
      end
    end

    st_nxt = s;
  end

endmodule

// File: rtl/core/arith_expression_syntax_checker_top.sv
// Infix expression syntax checker: takes one character per request and returns one
// verdict request after the character flagged last_char, or at once for an empty_expr
// request. One character is accepted every cycle unless input is stalled; the verdict is
// registered and appears in the cycle after its final character is accepted. The scan
// state is a single register updated by one pass of compare-and-flag logic per character,
// and a one-entry result register decouples the output: input is stalled only while that
// register holds a verdict the consumer has not taken.
module arith_expression_syntax_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char_code,
  input  logic        in_last_char,
  input  logic        in_empty_expr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_verdict
);

  aesc_pkg::scan_state_t scan_r;
  aesc_pkg::scan_state_t scan_nxt;
  logic                  has_result;
  logic [3:0]            verdict_nxt;
  logic                  out_valid_r;
  logic [3:0]            out_verdict_r;
  logic                  in_acc;

  // Accept whenever the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  aesc_step u_step (
    .st         (scan_r),
    .char_code  (in_char_code),
    .last_char  (in_last_char),
    .empty_expr (in_empty_expr),
    .st_nxt     (scan_nxt),
    .has_result (has_result),
    .verdict    (verdict_nxt)
  );

  // Advance scan state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= aesc_pkg::SCAN_CLEAR;
    end else if (in_acc) begin
      scan_r <= scan_nxt;
    end
  end

  // Hold the verdict until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= has_result;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_result) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// File: rtl/core/aesc_checker.sv
`include "arith_expression_syntax_checker_top_defines.svh"

module aesc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_char,
  input logic        in_empty_expr,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_verdict
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Stalled verdict holds
  `AESC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_verdict))
  // Empty request answers with the empty verdict next cycle
  `AESC_ASSERT_NXT(a_empty_verdict, in_acc && in_empty_expr, out_valid && (out_verdict == 4'd1))
  // A mid-expression character produces no verdict
  `AESC_ASSERT_NXT(a_no_spurious, in_acc && !in_last_char && !in_empty_expr, !out_valid)
  // Verdict codes stay in range
  `AESC_ASSERT_NOW(a_verdict_range, out_valid, out_verdict <= aesc_pkg::VERDICT_MAX)

endmodule

bind arith_expression_syntax_checker_top aesc_checker u_aesc_checker (.*);

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One character request as driven on the input channel
  typedef struct {
    logic [15:0] code;
    logic        last;
    logic        empty;
    logic        hold;
  } char_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_char_code = '0;
  logic        in_last_char = 1'b0;
  logic        in_empty_expr = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_verdict;

  char_req_t   pend_q[$];
  logic [15:0] expr_buf[$];
  logic [3:0]  verdict_q[$];
  aesc_pkg::scan_state_t expr_st = aesc_pkg::SCAN_CLEAR;
  char_req_t   nxt_req;
  logic [3:0]  want_verdict;
  bit          in_taken = 1'b0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          mismatches = 0;
  int          req_total = 0;

  arith_expression_syntax_checker_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_last_char  (in_last_char),
    .in_empty_expr (in_empty_expr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_verdict   (out_verdict)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Expression scan predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_num(logic [15:0] c);
    return c >= aesc_pkg::CH_ZERO && c <= aesc_pkg::CH_NINE;
  endfunction

  function automatic bit is_arith(logic [15:0] c);
    return c == aesc_pkg::CH_PLUS || c == aesc_pkg::CH_MINUS ||
           c == aesc_pkg::CH_STAR || c == aesc_pkg::CH_SLASH;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Keep only the earliest error of the expression
  task automatic note_error(logic [3:0] code);
    if (expr_st.first_error == aesc_pkg::VERDICT_OK) expr_st.first_error = code;
  endtask

  task automatic scan_char(logic [15:0] c);
    if (!expr_st.first_char_done) begin
      expr_st.first_char_done = 1'b1;
      expr_st.first_char_bad = !(c == aesc_pkg::CH_OPEN || is_num(c) ||
                                 c == aesc_pkg::CH_MINUS || c == aesc_pkg::CH_DOT);
    end
    if (is_arith(c) || c == aesc_pkg::CH_OPEN || c == aesc_pkg::CH_CLOSE ||
        c == aesc_pkg::CH_DOT || c == aesc_pkg::CH_SPACE)
      expr_st.saw_operator_char = 1'b1;

    // Close the zero divisor stretch on anything but zero, dot or space
    if (expr_st.zero_divisor_scan && c != aesc_pkg::CH_ZERO && c != aesc_pkg::CH_DOT &&
        c != aesc_pkg::CH_SPACE) begin
      expr_st.zero_divisor_scan = 1'b0;
      if (is_num(c)) begin
        if (expr_st.dot_error_deferred) note_error(aesc_pkg::VERDICT_MULTI_DOT);
      end else begin
        note_error(aesc_pkg::VERDICT_ZERO_DIV);
      end
      expr_st.dot_error_deferred = 1'b0;
    end

    if (c == aesc_pkg::CH_SPACE) begin
      expr_st.in_number_run = 1'b0;
      return;
    end

    // Check the first non-space character after a bracket or operator
    case (expr_st.lookahead_kind)
      aesc_pkg::LA_OPEN: begin
        if (c == aesc_pkg::CH_PLUS || c == aesc_pkg::CH_STAR || c == aesc_pkg::CH_SLASH ||
            c == aesc_pkg::CH_CLOSE)
          note_error(aesc_pkg::VERDICT_MALFORMED);
      end
      aesc_pkg::LA_CLOSE: begin
        if (is_num(c) || c == aesc_pkg::CH_OPEN || c == aesc_pkg::CH_DOT)
          note_error(aesc_pkg::VERDICT_MALFORMED);
      end
      aesc_pkg::LA_OP: begin
        if (is_arith(c) || c == aesc_pkg::CH_CLOSE) note_error(aesc_pkg::VERDICT_TWO_OPS);
        else if (expr_st.divide_pending && c == aesc_pkg::CH_ZERO)
          expr_st.zero_divisor_scan = 1'b1;
      end
      default: ;
    endcase
    expr_st.lookahead_kind = aesc_pkg::LA_NONE;
    expr_st.divide_pending = 1'b0;

    if (!is_num(c) && !is_arith(c) && c != aesc_pkg::CH_OPEN && c != aesc_pkg::CH_CLOSE &&
        c != aesc_pkg::CH_DOT)
      note_error(aesc_pkg::VERDICT_MALFORMED);

    // Track one dot per number
    if (is_num(c) || c == aesc_pkg::CH_DOT) begin
      if (!expr_st.in_number_run) begin
        expr_st.in_number_run = 1'b1;
        expr_st.dot_seen_in_run = (c == aesc_pkg::CH_DOT);
      end else if (c == aesc_pkg::CH_DOT) begin
        if (expr_st.dot_seen_in_run) begin
          if (expr_st.zero_divisor_scan) expr_st.dot_error_deferred = 1'b1;
          else note_error(aesc_pkg::VERDICT_MULTI_DOT);
        end
        expr_st.dot_seen_in_run = 1'b1;
      end
      return;
    end
    expr_st.in_number_run = 1'b0;

    // Bracket depth saturates at the counter's top value
    if (c == aesc_pkg::CH_OPEN) begin
      if (expr_st.bracket_depth >= aesc_pkg::DEPTH_MAX) note_error(aesc_pkg::VERDICT_TOO_DEEP);
      else expr_st.bracket_depth = expr_st.bracket_depth + aesc_pkg::DEPTH_ONE;
      expr_st.lookahead_kind = aesc_pkg::LA_OPEN;
    end else if (c == aesc_pkg::CH_CLOSE) begin
      if (expr_st.bracket_depth == '0) note_error(aesc_pkg::VERDICT_MALFORMED);
      else expr_st.bracket_depth = expr_st.bracket_depth - aesc_pkg::DEPTH_ONE;
      expr_st.lookahead_kind = aesc_pkg::LA_CLOSE;
    end else if (is_arith(c)) begin
      expr_st.lookahead_kind = aesc_pkg::LA_OP;
      expr_st.divide_pending = (c == aesc_pkg::CH_SLASH);
    end
  endtask

  // Advance the scan by one request and queue the verdict it yields
  task automatic predict_verdict(logic [15:0] c, logic last, logic empty);
    logic [3:0] v;
    if (empty) begin
      expr_st = aesc_pkg::SCAN_CLEAR;
      verdict_q.push_back(aesc_pkg::VERDICT_EMPTY);
      return;
    end
    scan_char(c);
    if (!last) return;
    if (expr_st.zero_divisor_scan) note_error(aesc_pkg::VERDICT_ZERO_DIV);
    if (expr_st.first_char_bad) v = aesc_pkg::VERDICT_MALFORMED;
    else if (!(c == aesc_pkg::CH_CLOSE || is_num(c) || c == aesc_pkg::CH_DOT))
      v = aesc_pkg::VERDICT_MALFORMED;
    else if (!expr_st.saw_operator_char) v = aesc_pkg::VERDICT_NUM_ONLY;
    else if (expr_st.first_error != aesc_pkg::VERDICT_OK) v = expr_st.first_error;
    else if (expr_st.bracket_depth != '0) v = aesc_pkg::VERDICT_UNBAL;
    else v = aesc_pkg::VERDICT_OK;
    expr_st = aesc_pkg::SCAN_CLEAR;
    verdict_q.push_back(v);
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: check verdicts, then predict from accepted input
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d with no request pending", out_verdict));
      end else begin
        want_verdict = verdict_q.pop_front();
        if (out_verdict !== want_verdict)
          flag_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict, want_verdict));
      end
    end
    if (in_taken) predict_verdict(in_char_code, in_last_char, in_empty_expr);
  end

  // ---------------------------------------------------------------------------
  // Drivers at the falling edge
  // ---------------------------------------------------------------------------

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the request until taken, then idle or send the next one
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pend_q.size() == 0 || (pend_q[0].hold && verdict_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt_req = pend_q.pop_front();
        in_char_code  <= nxt_req.code;
        in_last_char  <= nxt_req.last;
        in_empty_expr <= nxt_req.empty;
        in_valid      <= 1'b1;
        if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
        in_gap = pick_gap(in_calm);
      end
    end
  end

  // Stall the verdict side at random
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_req(logic [15:0] code, logic last, logic empty, logic hold);
    char_req_t q;
    q.code = code;
    q.last = last;
    q.empty = empty;
    q.hold = hold;
    pend_q.push_back(q);
    req_total++;
  endtask

  task automatic put_ch(logic [15:0] c);
    expr_buf.push_back(c);
  endtask

  // Move the built expression into the request queue
  task automatic flush_expr(bit hold, bit close);
    foreach (expr_buf[i])
      add_req(expr_buf[i], close && (i == expr_buf.size() - 1), 1'b0, hold && (i == 0));
    expr_buf.delete();
  endtask

  task automatic push_text(string s, bit hold);
    for (int i = 0; i < s.len(); i++) put_ch({8'h00, s[i]});
    flush_expr(hold, 1'b1);
  endtask

  function automatic logic [15:0] rand_sym();
    string abc;
    abc = "0123456789+-*/(). ax";
    return {8'h00, abc[$urandom_range(0, abc.len() - 1)]};
  endfunction

  task automatic put_digit(bit nonzero);
    logic [15:0] d;
    d = nonzero ? 16'($urandom_range(1, 9)) : 16'($urandom_range(0, 9));
    put_ch(aesc_pkg::CH_ZERO + d);
  endtask

  task automatic put_number();
    int n;
    int dot_at;
    bit has_dot;
    n = $urandom_range(1, 4);
    has_dot = ($urandom_range(0, 2) == 0);
    dot_at = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      if (has_dot && i == dot_at) put_ch(aesc_pkg::CH_DOT);
      put_digit(1'b0);
    end
    if (has_dot && dot_at == n) put_ch(aesc_pkg::CH_DOT);
    if ($urandom_range(0, 19) == 0) begin
      put_ch(aesc_pkg::CH_DOT);
      put_digit(1'b0);
    end
  endtask

  task automatic put_op(output logic [15:0] op);
    case ($urandom_range(0, 3))
      0: op = aesc_pkg::CH_PLUS;
      1: op = aesc_pkg::CH_MINUS;
      2: op = aesc_pkg::CH_STAR;
      default: op = aesc_pkg::CH_SLASH;
    endcase
    if ($urandom_range(0, 4) == 0) put_ch(aesc_pkg::CH_SPACE);
    put_ch(op);
    if ($urandom_range(0, 4) == 0) put_ch(aesc_pkg::CH_SPACE);
  endtask

  // Zero divisor: a zero followed by zeros, dots or spaces, maybe ended by a digit
  task automatic put_zero_run();
    int k;
    put_ch(aesc_pkg::CH_ZERO);
    k = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 2))
        0: put_ch(aesc_pkg::CH_ZERO);
        1: put_ch(aesc_pkg::CH_DOT);
        default: put_ch(aesc_pkg::CH_SPACE);
      endcase
    end
    if ($urandom_range(0, 1) == 0) put_digit(1'b1);
  endtask

  // Build a mostly well-formed expression, then damage it now and then
  task automatic gen_expr();
    int terms;
    logic [15:0] op;
    if ($urandom_range(0, 9) == 0) put_ch(aesc_pkg::CH_MINUS);
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        put_op(op);
        if (op == aesc_pkg::CH_SLASH && $urandom_range(0, 2) == 0) begin
          put_zero_run();
          continue;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        put_ch(aesc_pkg::CH_OPEN);
        put_number();
        put_op(op);
        put_number();
        put_ch(aesc_pkg::CH_CLOSE);
      end else begin
        put_number();
      end
    end
    if ($urandom_range(0, 3) == 0) expr_buf[$urandom_range(0, expr_buf.size() - 1)] = rand_sym();
    if ($urandom_range(0, 19) == 0) expr_buf.push_front(aesc_pkg::CH_OPEN);
    if ($urandom_range(0, 19) == 0) put_ch(rand_sym());
  endtask

  task automatic gen_noise(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) put_ch(16'($urandom_range(0, 65535)));
      else put_ch(rand_sym());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int r;

    // Directed expressions: every verdict and the corner cases of the scan
    push_text("1+2", 1'b0);
    add_req(16'h0000, 1'b0, 1'b1, 1'b0);
    add_req(16'hFFFF, 1'b1, 1'b1, 1'b0);
    push_text("+1", 1'b0);
    push_text("1+", 1'b0);
    push_text("123", 1'b0);
    push_text(".", 1'b0);
    push_text("-.5", 1'b0);
    push_text("1.2.3+1", 1'b0);
    push_text("1+*2", 1'b0);
    push_text("7/-0", 1'b0);
    push_text("1/0", 1'b0);
    push_text("1 / 00.5", 1'b0);
    push_text("1/0.0.1", 1'b0);
    push_text("1/0.0.+2", 1'b0);
    push_text("1/0 .0", 1'b0);
    push_text("(1+2", 1'b0);
    push_text("1)", 1'b0);
    push_text("(+1)", 1'b0);
    push_text("(1)2", 1'b0);
    push_text("1+ (2)", 1'b0);
    push_text("1+  ", 1'b0);
    push_text("1a+2", 1'b0);
    put_ch(aesc_pkg::CH_ONE);
    put_ch(aesc_pkg::CH_PLUS);
    put_ch(16'h4E00);
    put_ch(aesc_pkg::CH_ONE);
    flush_expr(1'b0, 1'b1);
    push_text("3.5*(2-1)/4", 1'b1);
    // Bracket depth past saturation, with the abandoned expression before it
    push_text("(1+", 1'b0);
    pend_q[pend_q.size() - 1].last = 1'b0;
    add_req(aesc_pkg::CH_SLASH, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 256; i++) put_ch(aesc_pkg::CH_OPEN);
    put_ch(aesc_pkg::CH_ONE);
    for (int i = 0; i < 255; i++) put_ch(aesc_pkg::CH_CLOSE);
    flush_expr(1'b0, 1'b1);

    // Random part: mostly shaped expressions, some soup, noise and aborts
    while (req_total < 1150) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        gen_expr();
        flush_expr($urandom_range(0, 39) == 0, 1'b1);
      end else if (r < 82) begin
        for (int i = $urandom_range(1, 10); i > 0; i--) put_ch(rand_sym());
        flush_expr(1'b0, 1'b1);
      end else if (r < 90) begin
        gen_noise($urandom_range(1, 5));
        flush_expr(1'b0, 1'b1);
      end else if (r < 95) begin
        gen_expr();
        flush_expr(1'b0, 1'b0);
        add_req(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
      end else begin
        add_req(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
      end
    end

    // Drain: all requests taken and all verdicts back before the end of the run
    wait (pend_q.size() == 0 && !in_valid);
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/aesc_pkg.sv
rtl/core/aesc_step.sv
rtl/core/arith_expression_syntax_checker_top.sv
rtl/core/aesc_checker.sv
bench/tb_top.sv
